// ===== rtl/core/ir_pulse_timing_decoder_assert.svh =====
// Assertion macros shared by the IR pulse timing decoder RTL.
// Each macro expects clk and rst_n to be in scope where it is used.
`ifndef IR_PULSE_TIMING_DECODER_ASSERT_SVH
`define IR_PULSE_TIMING_DECODER_ASSERT_SVH

// Implication-style check, sampled on the rising clock edge, off during reset
`define IPTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset
`define IPTD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/iptd_pkg.sv =====
// Package for the IR pulse timing decoder: types, codes and reset constants.
// No dependencies; used by iptd_frame_fsm and ir_pulse_timing_decoder.
`timescale 1ns / 1ps

package iptd_pkg;

    // Field widths
    localparam int TICK_W   = 8;
    localparam int CODE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Default number of bits in one frame
    localparam int CODE_BITS_DEFAULT = 8;

    // Register reset values
    localparam logic              CHANNEL_RESET     = 1'b1;
    localparam logic [TICK_W-1:0] START_EDGE_RESET  = 8'd40;
    localparam logic [TICK_W-1:0] START_QUIET_RESET = 8'd150;
    localparam logic [TICK_W-1:0] BIT_EDGE_RESET    = 8'd75;
    localparam logic [TICK_W-1:0] BIT_CHECK_RESET   = 8'd55;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_EDGE_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_QUIET_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_EDGE_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_CHECK_TICKS   = 3'd4;

    // Frame status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_NO_START = 2'd0,
        STATUS_DONE     = 2'd1,
        STATUS_ABORT    = 2'd2
    } status_t;

    // Decoder phases
    typedef enum logic [1:0] {
        PH_START_EDGE  = 2'd0,
        PH_START_QUIET = 2'd1,
        PH_BIT_EDGE    = 2'd2,
        PH_BIT_CHECK   = 2'd3
    } phase_t;

    // Configuration handed to the frame state machine
    typedef struct packed {
        logic              channel_select;
        logic [TICK_W-1:0] start_edge_ticks;
        logic [TICK_W-1:0] start_quiet_ticks;
        logic [TICK_W-1:0] bit_edge_ticks;
        logic [TICK_W-1:0] bit_check_ticks;
    } cfg_t;

    // One frame result from the state machine
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        status_t           status;
    } result_t;

endpackage

// ===== rtl/core/iptd_frame_fsm.sv =====
// Frame state machine of the IR pulse timing decoder: edge detect, windows, bit shift.
// Depends on iptd_pkg and ir_pulse_timing_decoder_assert.svh.
`timescale 1ns / 1ps
`include "ir_pulse_timing_decoder_assert.svh"

module iptd_frame_fsm #(
    parameter int CODE_BITS = iptd_pkg::CODE_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  iptd_pkg::cfg_t   cfg,
    input  logic             step,
    input  logic             level_low_pin,
    input  logic             level_high_pin,
    output iptd_pkg::result_t result
);
    import iptd_pkg::*;

    localparam int POS_W = $clog2(CODE_BITS + 1);

    phase_t             phase_reg,      phase_next;
    logic [TICK_W-1:0]  ticks_reg,      ticks_next;
    logic               prev_level_reg, prev_level_next;
    logic [POS_W-1:0]   pos_reg,        pos_next;
    logic [CODE_W-1:0]  code_reg,       code_next;

    logic               level;
    logic               edge_seen;
    logic [TICK_W-1:0]  limit;
    logic               timeout;
    logic               bit_val;
    logic [POS_W-1:0]   pos_inc;
    logic               last_bit;
    logic [CODE_W-1:0]  code_set;

    // Selected pin and falling edge against the previous tick
    assign level     = cfg.channel_select ? level_high_pin : level_low_pin;
    assign edge_seen = prev_level_reg & ~level;

    // Window limit of the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_START_EDGE:  limit = cfg.start_edge_ticks;
            PH_START_QUIET: limit = cfg.start_quiet_ticks;
            PH_BIT_EDGE:    limit = cfg.bit_edge_ticks;
            PH_BIT_CHECK:   limit = cfg.bit_check_ticks;
            default:        limit = cfg.start_edge_ticks;
        endcase
    end

    assign timeout = (ticks_reg >= limit);

    // Bit value: zero on a missed bit edge, inverted level after the check window
    assign bit_val  = (phase_reg == PH_BIT_CHECK) ? ~level : 1'b0;
    assign pos_inc  = pos_reg + POS_W'(1);
    assign last_bit = (pos_inc == POS_W'(CODE_BITS));
    // bits at or past the output width shift out to zero
    assign code_set = code_reg | (CODE_W'(bit_val) << pos_reg);

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        ticks_next      = ticks_reg;
        prev_level_next = prev_level_reg;
        pos_next        = pos_reg;
        code_next       = code_reg;
        if (step)
        begin
            prev_level_next = level;
            ticks_next      = ticks_reg + TICK_W'(1);
            unique case (phase_reg)
                PH_START_EDGE:
                begin
                    if (edge_seen || timeout)
                    begin
                        phase_next = edge_seen ? PH_START_QUIET : PH_START_EDGE;
                        ticks_next = '0;
                    end
                end
                PH_START_QUIET:
                begin
                    if (edge_seen || timeout)
                    begin
                        phase_next = edge_seen ? PH_START_EDGE : PH_BIT_EDGE;
                        ticks_next = '0;
                        pos_next   = '0;
                        code_next  = '0;
                    end
                end
                PH_BIT_EDGE, PH_BIT_CHECK:
                begin
                    if (edge_seen && phase_reg == PH_BIT_EDGE)
                    begin
                        phase_next = PH_BIT_CHECK;
                        ticks_next = '0;
                    end
                    else if (edge_seen)
                    begin
                        // double edge aborts the frame
                        phase_next = PH_START_EDGE;
                        ticks_next = '0;
                        pos_next   = '0;
                        code_next  = '0;
                    end
                    else if (timeout)
                    begin
                        ticks_next = '0;
                        if (last_bit)
                        begin
                            phase_next = PH_START_EDGE;
                            pos_next   = '0;
                            code_next  = '0;
                        end
                        else
                        begin
                            phase_next = PH_BIT_EDGE;
                            pos_next   = pos_inc;
                            code_next  = code_set;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_START_EDGE;
                    ticks_next = '0;
                end
            endcase
        end
    end

    // Frame result for this tick
    always_comb
    begin
        result        = '0;
        result.status = STATUS_NO_START;
        if (step)
        begin
            unique case (phase_reg)
                PH_START_EDGE:
                begin
                    result.valid = ~edge_seen & timeout;
                end
                PH_START_QUIET:
                begin
                    result.valid = edge_seen;
                end
                PH_BIT_EDGE:
                begin
                    result.valid  = ~edge_seen & timeout & last_bit;
                    result.code   = code_set;
                    result.status = STATUS_DONE;
                end
                PH_BIT_CHECK:
                begin
                    result.valid  = edge_seen | (timeout & last_bit);
                    result.code   = edge_seen ? code_reg : code_set;
                    result.status = edge_seen ? STATUS_ABORT : STATUS_DONE;
                end
                default:
                begin
                    result.valid = 1'b0;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START_EDGE;
            ticks_reg      <= '0;
            prev_level_reg <= 1'b1;
            pos_reg        <= '0;
            code_reg       <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            ticks_reg      <= ticks_next;
            prev_level_reg <= prev_level_next;
            pos_reg        <= pos_next;
            code_reg       <= code_next;
        end
    end

    // Checks
    `IPTD_ASSERT(a_pos_in_range, pos_reg < POS_W'(CODE_BITS), "bit position past frame length")
    `IPTD_ASSERT(a_result_restarts, result.valid |=> phase_reg == PH_START_EDGE,
                 "decoder did not restart after a frame result")
    `IPTD_ASSERT(a_start_clean, phase_reg == PH_START_EDGE || phase_reg == PH_START_QUIET |->
                 code_reg == '0 && pos_reg == '0, "frame bits left over in start phases")

endmodule

// ===== rtl/core/ir_pulse_timing_decoder.sv =====
// Top level of the IR pulse timing decoder: config registers, input stage, result register.
// Depends on iptd_pkg, iptd_frame_fsm and ir_pulse_timing_decoder_assert.svh.
// A tick beat held in the input register passes its frame result to the result register.
// Throughput: one tick beat per cycle; while a result beat is stalled the input register takes
// one more tick beat and then stalls, whether or not that tick ends a frame.
// Reset: async active low; clears the frame state machine and valids and loads register defaults.
`timescale 1ns / 1ps
`include "ir_pulse_timing_decoder_assert.svh"

module ir_pulse_timing_decoder #(
    parameter int CODE_BITS = iptd_pkg::CODE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_write_en,
    input  logic [iptd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iptd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // tick input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               level_low_pin,
    input  logic                               level_high_pin,
    // frame result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [iptd_pkg::CODE_W-1:0]        frame_code,
    output logic [iptd_pkg::STATUS_W-1:0]      frame_status
);
    import iptd_pkg::*;

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic               low_pin_reg;
    logic               high_pin_reg;
    logic               out_valid_reg,  out_valid_next;
    logic [CODE_W-1:0]  code_reg;
    status_t            status_reg;
    logic               proc_go;
    logic               in_take;
    result_t            result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_select    <= CHANNEL_RESET;
            cfg_reg.start_edge_ticks  <= START_EDGE_RESET;
            cfg_reg.start_quiet_ticks <= START_QUIET_RESET;
            cfg_reg.bit_edge_ticks    <= BIT_EDGE_RESET;
            cfg_reg.bit_check_ticks   <= BIT_CHECK_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_CHANNEL_SELECT:    cfg_reg.channel_select    <= cfg_data[0];
                REG_START_EDGE_TICKS:  cfg_reg.start_edge_ticks  <= cfg_data;
                REG_START_QUIET_TICKS: cfg_reg.start_quiet_ticks <= cfg_data;
                REG_BIT_EDGE_TICKS:    cfg_reg.bit_edge_ticks    <= cfg_data;
                REG_BIT_CHECK_TICKS:   cfg_reg.bit_check_ticks   <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Handshake: the held tick moves on whenever the result register can take a beat
    assign proc_go  = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = in_valid_reg & ~proc_go;
    assign in_take  = in_valid & ~in_stall;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take || proc_go)
        begin
            in_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            low_pin_reg  <= level_low_pin;
            high_pin_reg <= level_high_pin;
        end
    end

    // Frame decoding
    iptd_frame_fsm #(
        .CODE_BITS (CODE_BITS)
    ) u_frame_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .step           (proc_go),
        .level_low_pin  (low_pin_reg),
        .level_high_pin (high_pin_reg),
        .result         (result)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        if (proc_go)
        begin
            out_valid_next = result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && result.valid)
        begin
            code_reg   <= result.code;
            status_reg <= result.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_code   = code_reg;
    assign frame_status = status_reg;

    // Checks
    `IPTD_ASSERT(a_no_start_zero, out_valid_reg && status_reg == STATUS_NO_START |->
                 code_reg == '0, "no-start result carries a nonzero code")
    `IPTD_ASSERT(a_tick_held, in_valid_reg && !proc_go |=> in_valid_reg,
                 "held tick dropped from the input stage")
    `IPTD_NEVER(a_no_overwrite, proc_go && result.valid && out_valid_reg && out_stall,
                "result written over a stalled beat")

endmodule
